// ===== rtl/conv3x3_divide_filter_macros.svh =====
// Assertion macros shared by the checker.
`ifndef CONV3X3_DIVIDE_FILTER_MACROS_SVH
`define CONV3X3_DIVIDE_FILTER_MACROS_SVH

// Implication checked on every edge outside reset.
`define C3_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication checked outside reset.
`define C3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

// ===== rtl/c3df_pkg.sv =====
`default_nettype none
package c3df_pkg;
    localparam int MaxWidth = 1024;
    localparam int MaxHeight = 4096;
    localparam int ColW = 10;
    localparam int RowW = 12;
    localparam int SumW = 20;
    localparam int MagW = 19;
    localparam int DivW = 16;
    localparam int QDepth = 4;

    localparam logic [2:0] REG_KTOP = 3'd0;
    localparam logic [2:0] REG_KMID = 3'd1;
    localparam logic [2:0] REG_KBOT = 3'd2;
    localparam logic [2:0] REG_DIV = 3'd3;
    localparam logic [2:0] REG_WIDTH = 3'd4;
    localparam logic [2:0] REG_HEIGHT = 3'd5;

    // One job handed from the window front to the divider back.
    typedef struct packed {
        logic            neg;
        logic [MagW-1:0] mag;
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
        logic            last;
    } job_t;
endpackage
`default_nettype wire

// ===== rtl/c3df_front.sv =====
`default_nettype none
module c3df_front
    import c3df_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  pixel,
    input  wire logic [23:0] ktop,
    input  wire logic [23:0] kmid,
    input  wire logic [23:0] kbot,
    input  wire logic [10:0] width,
    input  wire logic [12:0] height,
    input  wire logic        q_full,
    output logic             job_valid,
    output job_t             job
);
    // Stage 0: accept pixel, read line stores (registered).
    // Stage 1: nine products.  Stage 2: sum and job out.
    logic [7:0] store_a [MaxWidth];
    logic [7:0] store_b [MaxWidth];
    logic [7:0] win_reg [6];
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    logic [ColW-1:0] idx;
    logic s0_valid_reg, s0_emit_reg, s0_last_reg;
    logic [7:0] s0_bot_reg, s0_top_reg, s0_mid_reg;
    logic [ColW-1:0] s0_col_reg;
    logic [RowW-1:0] s0_row_reg;
    logic s1_valid_reg, s1_last_reg;
    logic signed [16:0] prod_reg [9];
    logic [ColW-1:0] s1_col_reg;
    logic [RowW-1:0] s1_row_reg;
    logic [7:0] p [9];
    logic [7:0] k [9];
    logic signed [SumW-1:0] sum;
    logic stall, take, emit, fwd_valid;
    logic [7:0] top_now, mid_now;
    logic [10:0] c_ext;
    logic [12:0] r_ext;

    always_comb
    begin
        if (width < 11'd3) w_eff = 11'd3;
        else if (width > 11'(MaxWidth)) w_eff = 11'(MaxWidth);
        else w_eff = width;
        if (height < 13'd3) h_eff = 13'd3;
        else if (height > 13'(MaxHeight)) h_eff = 13'(MaxHeight);
        else h_eff = height;
    end

    // Hold the front while the queue can't take the words in flight.
    assign stall = q_full;
    assign in_ready = !stall && !s0_valid_reg;
    assign take = in_valid && in_ready;
    assign idx = col_reg;
    assign c_ext = {1'b0, col_reg};
    assign r_ext = {1'b0, row_reg};
    assign emit = c_ext >= 11'd2 && c_ext <= w_eff - 11'd1 && r_ext >= 13'd2
        && r_ext <= h_eff - 13'd1;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s0_top_reg <= store_b[idx];
            s0_mid_reg <= store_a[idx];
        end
        if (s0_valid_reg)
        begin
            store_b[s0_col_reg] <= s0_mid_reg;
            store_a[s0_col_reg] <= s0_bot_reg;
        end
    end

    assign top_now = s0_top_reg;
    assign mid_now = s0_mid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            job_valid <= 1'b0;
            for (int i = 0; i < 6; i++) win_reg[i] <= '0;
        end
        else
        begin
            s0_valid_reg <= take;
            if (take)
            begin
                s0_bot_reg <= pixel;
                s0_col_reg <= col_reg;
                s0_row_reg <= row_reg;
                s0_emit_reg <= emit;
                s0_last_reg <= (c_ext == w_eff - 11'd1) && (r_ext == h_eff - 13'd1);
                if (c_ext + 11'd1 >= w_eff)
                begin
                    col_reg <= '0;
                    row_reg <= (r_ext + 13'd1 >= h_eff) ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            if (s0_valid_reg)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top_now;
                win_reg[4] <= mid_now;
                win_reg[5] <= s0_bot_reg;
            end
            s1_valid_reg <= s0_valid_reg && s0_emit_reg;
            job_valid <= s1_valid_reg;
        end
    end

    always_comb
    begin
        p[0] = win_reg[0]; p[1] = win_reg[3]; p[2] = top_now;
        p[3] = win_reg[1]; p[4] = win_reg[4]; p[5] = mid_now;
        p[6] = win_reg[2]; p[7] = win_reg[5]; p[8] = s0_bot_reg;
        for (int j = 0; j < 3; j++)
        begin
            k[j] = ktop[8*j +: 8];
            k[3+j] = kmid[8*j +: 8];
            k[6+j] = kbot[8*j +: 8];
        end
        fwd_valid = s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s0_valid_reg)
        begin
            for (int j = 0; j < 9; j++)
                prod_reg[j] <= $signed({9'd0, p[j]}) * $signed({{9{k[j][7]}}, k[j]});
            s1_col_reg <= s0_col_reg - 1'b1;
            s1_row_reg <= s0_row_reg - 1'b1;
            s1_last_reg <= s0_last_reg;
        end
    end

    always_comb
    begin
        sum = '0;
        for (int j = 0; j < 9; j++)
            sum = sum + SumW'(prod_reg[j]);
    end

    always_ff @(posedge clk)
    begin
        if (fwd_valid)
        begin
            job.neg <= sum[SumW-1];
            job.mag <= sum[SumW-1] ? MagW'(-sum) : MagW'(sum);
            job.col <= s1_col_reg;
            job.row <= s1_row_reg;
            job.last <= s1_last_reg;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/c3df_queue.sv =====
`default_nettype none
module c3df_queue
    import c3df_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_data,
    input  wire logic pop,
    output logic      not_empty,
    output job_t      head,
    output logic      almost_full
);
    localparam int AW = $clog2(QDepth);
    job_t mem_reg [QDepth];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0] cnt_reg;

    assign not_empty = cnt_reg != '0;
    assign head = mem_reg[rd_reg];
    // Two jobs may still be in flight in the front pipe.
    assign almost_full = cnt_reg >= (AW+1)'(QDepth - 3);

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0;
            rd_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wr_reg <= wr_reg + 1'b1;
            if (pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/c3df_back.sv =====
`default_nettype none
module c3df_back
    import c3df_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            job_valid,
    input  wire job_t            job,
    output logic                 job_pop,
    input  wire logic [DivW-1:0] divisor,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output logic [7:0]           value,
    output logic                 overflow,
    output logic [ColW-1:0]      out_col,
    output logic [RowW-1:0]      out_row,
    output logic                 frame_last
);
    // Restoring divider, one quotient bit per cycle.
    localparam int CntW = $clog2(MagW + 1);
    logic busy_reg;
    logic [CntW-1:0] cnt_reg;
    logic [MagW-1:0] quo_reg;
    logic [DivW:0] rem_reg;
    logic [DivW-1:0] d_reg;
    job_t job_reg;
    logic [DivW:0] trial;
    logic [DivW:0] shifted;
    logic [MagW-1:0] q;

    assign job_pop = job_valid && !busy_reg && !out_valid;
    assign shifted = {rem_reg[DivW-1:0], quo_reg[MagW-1]};
    assign trial = shifted - {1'b0, d_reg};
    assign q = job_reg.neg ? MagW'(-quo_reg) : quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            out_valid <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            if (job_pop)
            begin
                busy_reg <= 1'b1;
                cnt_reg <= CntW'(MagW);
                job_reg <= job;
                quo_reg <= job.mag;
                rem_reg <= '0;
                d_reg <= (divisor == '0) ? DivW'(1) : divisor;
            end
            else if (busy_reg)
            begin
                if (cnt_reg != '0)
                begin
                    if (!trial[DivW])
                    begin
                        rem_reg <= trial;
                        quo_reg <= {quo_reg[MagW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted;
                        quo_reg <= {quo_reg[MagW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - 1'b1;
                end
                else
                    busy_reg <= 1'b0;
            end
            if (busy_reg && cnt_reg == '0 && !out_valid)
                out_valid <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && cnt_reg == '0 && !out_valid)
        begin
            value <= q[7:0];
            overflow <= job_reg.neg ? (quo_reg != '0) : (quo_reg > MagW'(255));
            out_col <= job_reg.col;
            out_row <= job_reg.row;
            frame_last <= job_reg.last;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/conv3x3_divide_filter.sv =====
// conv3x3_divide_filter: 3x3 signed-kernel convolution over a raster stream.
// Input channel in_valid/in_ready carries one 8-bit pixel per word in raster
// order. Output channel out_valid/out_ready carries value, overflow, out_col,
// out_row and frame_last for each interior centre; border pixels give none.
// Config channel cfg_valid/cfg_ready writes kernel rows, divisor, width and
// height by index; write only while idle. A result passes three front
// stages, the queue, then a 19-step restoring divider that takes one
// quotient bit per cycle. The divider takes a new job only once the last
// result has been taken; the front takes a new pixel only after the last
// one leaves the first front stage, and only while the queue is empty.
// Reset clears counters, window and queue; line stores are not cleared.
// A stalled receiver holds the result; the next job waits in the queue and
// in_ready drops until it moves on.
`default_nettype none
module conv3x3_divide_filter
    import c3df_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  pixel,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       value,
    output logic             overflow,
    output logic [9:0]       out_col,
    output logic [11:0]      out_row,
    output logic             frame_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    logic [23:0] ktop_reg, kmid_reg, kbot_reg;
    logic [15:0] div_reg;
    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic job_valid, q_ne, q_full, pop;
    job_t job, head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ktop_reg <= '0;
            kmid_reg <= 24'd256;
            kbot_reg <= '0;
            div_reg <= 16'd1;
            width_reg <= 11'd1024;
            height_reg <= 13'd4096;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_KTOP:   ktop_reg <= cfg_data;
                REG_KMID:   kmid_reg <= cfg_data;
                REG_KBOT:   kbot_reg <= cfg_data;
                REG_DIV:    div_reg <= cfg_data[15:0];
                REG_WIDTH:  width_reg <= cfg_data[10:0];
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    c3df_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .pixel(pixel), .ktop(ktop_reg), .kmid(kmid_reg), .kbot(kbot_reg),
        .width(width_reg), .height(height_reg), .q_full(q_full),
        .job_valid(job_valid), .job(job)
    );

    c3df_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(job_valid), .push_data(job),
        .pop(pop), .not_empty(q_ne), .head(head), .almost_full(q_full)
    );

    c3df_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(q_ne), .job(head), .job_pop(pop),
        .divisor(div_reg), .out_valid(out_valid), .out_ready(out_ready),
        .value(value), .overflow(overflow), .out_col(out_col),
        .out_row(out_row), .frame_last(frame_last)
    );
endmodule
`default_nettype wire

// ===== rtl/c3df_checker.sv =====
`default_nettype none
`include "conv3x3_divide_filter_macros.svh"
module c3df_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] value,
    input wire logic       overflow,
    input wire logic [9:0] out_col,
    input wire logic [11:0] out_row
);
    `C3_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(value))
    `C3_ASSERT_NEXT(a_flag, clk, rst_n, out_valid && !out_ready, $stable(overflow))
    `C3_ASSERT_IMP(a_col, clk, rst_n, out_valid, out_col >= 10'd1)
    `C3_ASSERT_IMP(a_row, clk, rst_n, out_valid, out_row >= 12'd1)
endmodule

bind conv3x3_divide_filter c3df_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .value(value), .overflow(overflow), .out_col(out_col), .out_row(out_row)
);
`default_nettype wire
